FILE: rtl/core/ipcpd_pkg.sv
// Package for the inverse Park/Clarke PWM duty block.
// Holds pipeline stage indices, fixed-point constants and the pipeline control type.
// No dependencies.
`default_nettype none

package ipcpd_pkg;

  localparam int NumStages   = 10;
  localparam int SineStages  = 5;

  localparam int StgIn    = 0;
  localparam int StgSine  = 1;
  localparam int StgProd  = StgSine + SineStages;
  localparam int StgClamp = StgProd + 1;
  localparam int StgScale = StgClamp + 1;
  localparam int StgOut   = StgScale + 1;

  localparam logic [15:0] ThirdTurn   = 16'd21845;
  localparam logic [15:0] QuarterTurn = 16'd16384;
  localparam logic [14:0] QuadSpan    = 15'd16384;

  localparam logic [15:0] PolyC1 = 16'd51472;
  localparam logic [14:0] PolyC2 = 15'd21024;
  localparam logic [11:0] PolyC3 = 12'd2320;
  localparam logic [16:0] SineMax = 17'd32768;

  localparam logic [26:0] VmaxQ23    = 27'd100663296;
  localparam logic [6:0]  ScaleNum   = 7'd125;
  localparam logic [15:0] Recip3     = 16'd43691;
  localparam logic [10:0] DutyOffset = 11'd500;
  localparam logic [10:0] DutyMin    = 11'd500;
  localparam logic [10:0] DutyMax    = 11'd1500;

  typedef struct packed {
    logic [NumStages-1:0] en;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/ipcpd_ctrl.sv
// Pipeline control for the inverse Park/Clarke PWM duty block.
// Tracks a valid bit per stage and lets bubbles collapse; uses ipcpd_pkg.
`default_nettype none

module ipcpd_ctrl
  import ipcpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output pipe_ctrl_t      ctrl
);

  logic [NumStages-1:0] valid;

  always_comb begin
    ctrl.en[NumStages-1] = ~valid[NumStages-1] | m_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ctrl.en[k] = ~valid[k] | ctrl.en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctrl.en[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (ctrl.en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign s_tready = ctrl.en[0];
  assign m_tvalid = valid[NumStages-1];

endmodule

`default_nettype wire

FILE: rtl/core/ipcpd_sine.sv
// Five-stage sine evaluator: quantized angle, quarter-wave odd polynomial, sign.
// Result is signed Q1.15 in -32768..32768; uses ipcpd_pkg.
`default_nettype none

module ipcpd_sine
  import ipcpd_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
)
(
  input  wire logic                  clk,
  input  wire logic [SineStages-1:0] en,
  input  wire logic [15:0]           ang,
  output logic signed [16:0]         sine
);

  localparam int Drop = 16 - SINE_TABLE_BITS;

  logic [15:0] qa;
  logic [14:0] r_mir;
  logic [15:0] x_a;
  logic        neg_a;

  logic [31:0] xx;
  logic [15:0] x_b;
  logic [15:0] x2_b;
  logic        neg_b;

  logic [27:0] t_mul;
  logic [15:0] x_c;
  logic [15:0] x2_c;
  logic [14:0] inner_c;
  logic        neg_c;

  logic [30:0] p_mul;
  logic [15:0] x_d;
  logic [14:0] p_d;
  logic        neg_d;

  logic [15:0] f_e;
  logic [31:0] s_mul;
  logic [16:0] s_lim;

  assign qa    = (ang >> Drop) << Drop;
  assign r_mir = qa[14] ? (QuadSpan - {1'b0, qa[13:0]}) : {1'b0, qa[13:0]};
  assign xx    = 32'(x_a) * 32'(x_a);
  assign t_mul = 28'(x2_b) * 28'(PolyC3);
  assign p_mul = 31'(x2_c) * 31'(inner_c);
  assign f_e   = PolyC1 - {1'b0, p_d};
  assign s_mul = 32'(x_d) * 32'(f_e);
  assign s_lim = (s_mul[31:15] > SineMax) ? SineMax : s_mul[31:15];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_a   <= {r_mir, 1'b0};
      neg_a <= qa[15];
    end
    if (en[1]) begin
      x_b   <= x_a;
      x2_b  <= xx[30:15];
      neg_b <= neg_a;
    end
    if (en[2]) begin
      x_c     <= x_b;
      x2_c    <= x2_b;
      inner_c <= PolyC2 - {3'b000, t_mul[26:15]};
      neg_c   <= neg_b;
    end
    if (en[3]) begin
      x_d   <= x_c;
      p_d   <= p_mul[29:15];
      neg_d <= neg_c;
    end
    if (en[4]) begin
      sine <= neg_d ? -$signed(s_lim) : $signed(s_lim);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ipcpd_phase.sv
// One phase: sine and cosine, voltage products, clamp to 0..12 V and duty scaling.
// Instantiates ipcpd_sine twice; uses ipcpd_pkg.
`default_nettype none

module ipcpd_phase
  import ipcpd_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
)
(
  input  wire logic               clk,
  input  wire pipe_ctrl_t         ctrl,
  input  wire logic [15:0]        ang,
  input  wire logic signed [15:0] uq,
  input  wire logic signed [15:0] ud,
  output logic [10:0]             duty
);

  logic signed [16:0] sin_q;
  logic signed [16:0] cos_q;
  logic [15:0]        ang_cos;
  logic signed [15:0] uq_pipe [SineStages];
  logic signed [15:0] ud_pipe [SineStages];

  logic signed [32:0] prod_c;
  logic signed [32:0] prod_s;
  logic signed [33:0] diff;
  logic [26:0]        volt;
  logic [33:0]        n_mul;
  logic [11:0]        m_q;
  logic [27:0]        q_mul;

  assign ang_cos = ang + QuarterTurn;

  ipcpd_sine #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sin (
    .clk  (clk),
    .en   (ctrl.en[StgSine +: SineStages]),
    .ang  (ang),
    .sine (sin_q)
  );

  ipcpd_sine #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_cos (
    .clk  (clk),
    .en   (ctrl.en[StgSine +: SineStages]),
    .ang  (ang_cos),
    .sine (cos_q)
  );

  assign diff  = 34'(prod_c) - 34'(prod_s);
  assign n_mul = 34'(volt) * 34'(ScaleNum);
  assign q_mul = 28'(m_q) * 28'(Recip3);

  always_ff @(posedge clk) begin
    for (int k = 0; k < SineStages; k++) begin
      if (ctrl.en[StgSine + k]) begin
        if (k == 0) begin
          uq_pipe[k] <= uq;
          ud_pipe[k] <= ud;
        end else begin
          uq_pipe[k] <= uq_pipe[k-1];
          ud_pipe[k] <= ud_pipe[k-1];
        end
      end
    end
    if (ctrl.en[StgProd]) begin
      prod_c <= cos_q * ud_pipe[SineStages-1];
      prod_s <= sin_q * uq_pipe[SineStages-1];
    end
    if (ctrl.en[StgClamp]) begin
      if (diff[33]) begin
        volt <= '0;
      end else if (diff > $signed({7'b0000000, VmaxQ23})) begin
        volt <= VmaxQ23;
      end else begin
        volt <= diff[26:0];
      end
    end
    if (ctrl.en[StgScale]) begin
      m_q <= n_mul[33:22];
    end
    if (ctrl.en[StgOut]) begin
      duty <= q_mul[27:17] + DutyOffset;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/inverse_park_clarke_pwm_duty_top.sv
// Channel  | Signals                          | Word contents
// ---------+----------------------------------+----------------------------------------
// in       | s_tvalid s_tready s_tdata s_tuser | voltages, angle, time and velocity
// out      | m_tvalid m_tready m_tdata         | three PWM compare values
//
// One word is accepted per clock while s_tready is high. Its result is presented from
// the last of ten register stages (five of them in the sine unit).
// Reset clears only the stage valid bits, and no clearing pass is needed.
// A stalled output holds its word; empty stages upstream still fill.
// Top level of the inverse Park/Clarke PWM duty block.
// Depends on ipcpd_pkg, ipcpd_ctrl, ipcpd_sine and ipcpd_phase.
`default_nettype none

module inverse_park_clarke_pwm_duty_top
  import ipcpd_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
)
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // voltage_q[15:0], voltage_d[31:16], angle[47:32], time_ms[79:48], velocity[95:80]
  input  wire logic [95:0] s_tdata,
  // command[0]
  input  wire logic [0:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // duty_a[10:0], duty_b[21:11], duty_c[32:22], zero padding above
  output logic [39:0]      m_tdata
);

  pipe_ctrl_t         ctrl;
  logic [15:0]        ol_mul;
  logic [15:0]        ang0;
  logic signed [15:0] uq0;
  logic signed [15:0] ud0;
  logic [15:0]        ang_b;
  logic [15:0]        ang_c;
  logic [10:0]        duty_a;
  logic [10:0]        duty_b;
  logic [10:0]        duty_c;

  ipcpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctrl     (ctrl)
  );

  assign ol_mul = s_tdata[63:48] * s_tdata[95:80];

  always_ff @(posedge clk) begin
    if (ctrl.en[StgIn]) begin
      uq0 <= $signed(s_tdata[15:0]);
      if (s_tuser[0]) begin
        ang0 <= ol_mul;
        ud0  <= '0;
      end else begin
        ang0 <= s_tdata[47:32];
        ud0  <= $signed(s_tdata[31:16]);
      end
    end
  end

  assign ang_b = ang0 - ThirdTurn;
  assign ang_c = ang0 + ThirdTurn;

  ipcpd_phase #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_phase_a (
    .clk (clk), .ctrl (ctrl), .ang (ang0), .uq (uq0), .ud (ud0), .duty (duty_a)
  );

  ipcpd_phase #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_phase_b (
    .clk (clk), .ctrl (ctrl), .ang (ang_b), .uq (uq0), .ud (ud0), .duty (duty_b)
  );

  ipcpd_phase #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_phase_c (
    .clk (clk), .ctrl (ctrl), .ang (ang_c), .uq (uq0), .ud (ud0), .duty (duty_c)
  );

  assign m_tdata = {7'b0000000, duty_c, duty_b, duty_a};

`ifndef ASSERT_OFF
  a_empty_after_reset : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Pipeline not empty after reset.");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("Input stalled while the output stage is empty.");

  a_duty_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (duty_a >= DutyMin && duty_a <= DutyMax &&
                  duty_b >= DutyMin && duty_b <= DutyMax &&
                  duty_c >= DutyMin && duty_c <= DutyMax))
    else $error("Duty value outside of its range.");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for inverse_park_clarke_pwm_duty_top: predicts the three PWM duty values
// for each accepted input word and compares them with the output stream in order.
// Depends on the RTL top level only; stimulus mixes directed corners and random words.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SineBits = 10;
  localparam int PipeLatency = 10;
  localparam int WatchdogLimit = 1000;
  localparam int VoltSmall = 3200;
  localparam logic [15:0] QuarterTurnUnits = 16'd16384;
  localparam logic [15:0] ThirdTurnUnits = 16'd21845;
  localparam longint unsigned PolyLin = 51472;
  localparam longint unsigned PolyCube = 21024;
  localparam longint unsigned PolyFifth = 2320;
  localparam longint unsigned SineFull = 32768;
  localparam longint VmaxQ23 = 64'd100663296;
  localparam longint HalfSupplyQ23 = 64'd50331648;
  localparam longint DutySpan = 500;
  localparam longint DutyBase = 500;

  typedef enum logic {
    CmdGivenAngle = 1'b0,
    CmdOpenLoop   = 1'b1
  } angle_src_e;

  typedef struct packed {
    logic [10:0] duty_c;
    logic [10:0] duty_b;
    logic [10:0] duty_a;
  } duty_set_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  duty_set_t   pending_duties[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 1;
  bit          bursty = 1'b1;
  bit          full_rate = 1'b0;
  logic [9:0]  stall_phase = '0;

  inverse_park_clarke_pwm_duty_top #(
    .SINE_TABLE_BITS(SineBits)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int sine_of(input logic [15:0] ang);
    logic [15:0] qa;
    logic [1:0] quad;
    longint unsigned r, x, x2, inner, s;
    qa = (ang >> (16 - SineBits)) << (16 - SineBits);
    quad = qa[15:14];
    r = qa[13:0];
    if (quad[0]) begin
      r = 64'd16384 - r;
    end
    x = r << 1;
    x2 = (x * x) >> 15;
    inner = PolyCube - ((PolyFifth * x2) >> 15);
    s = (x * (PolyLin - ((x2 * inner) >> 15))) >> 15;
    if (s > SineFull) begin
      s = SineFull;
    end
    return quad[1] ? -int'(s) : int'(s);
  endfunction

  function automatic logic [10:0] phase_duty(input logic [15:0] ang, input int vq, input int vd);
    longint c, s, u;
    c = sine_of(ang + QuarterTurnUnits);
    s = sine_of(ang);
    u = c * longint'(vd) - s * longint'(vq);
    if (u < 0) begin
      u = 0;
    end
    if (u > VmaxQ23) begin
      u = VmaxQ23;
    end
    return 11'((u * DutySpan) / HalfSupplyQ23 + DutyBase);
  endfunction

  function automatic duty_set_t predict_duties(input logic cmd, input logic [95:0] word);
    logic [15:0] ang, ticks, vel;
    int vq, vd;
    duty_set_t d;
    vq = $signed(word[15:0]);
    vd = $signed(word[31:16]);
    ang = word[47:32];
    ticks = word[63:48];
    vel = word[95:80];
    if (cmd == CmdOpenLoop) begin
      ang = ticks * vel;
      vd = 0;
    end
    d.duty_a = phase_duty(ang, vq, vd);
    d.duty_b = phase_duty(ang - ThirdTurnUnits, vq, vd);
    d.duty_c = phase_duty(ang + ThirdTurnUnits, vq, vd);
    return d;
  endfunction

  task automatic check_field(input string field, input logic [10:0] want, input logic [10:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t %s: expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // The receiver cycles through always-ready, random, mostly-ready and long-stall patterns.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 10'd1;
    if (full_rate) begin
      m_tready <= 1'b1;
    end else begin
      case (stall_phase[9:8])
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= 1'($urandom_range(0, 1));
        2'd2: m_tready <= (stall_phase[1:0] != 2'd0);
        default: m_tready <= stall_phase[4];
      endcase
    end
  end

  always @(posedge clk) begin : scoreboard
    duty_set_t got;
    duty_set_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[32:0];
        if (pending_duties.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected word: expected none, actual %h", $time, got);
        end else begin
          want = pending_duties.pop_front();
          check_field("duty_a", want.duty_a, got.duty_a);
          check_field("duty_b", want.duty_b, got.duty_b);
          check_field("duty_c", want.duty_c, got.duty_c);
        end
      end
      if (s_tvalid && s_tready) begin
        pending_duties.push_back(predict_duties(s_tuser[0], s_tdata));
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("inverse_park_clarke_pwm_duty_top: mismatch");
      $finish;
    end
  end

  task automatic send_word(input angle_src_e src, input logic [15:0] vq, input logic [15:0] vd,
                           input logic [15:0] ang, input logic [31:0] ticks,
                           input logic [15:0] vel);
    s_tdata <= {vel, ticks, ang, vd, vq};
    s_tuser <= src;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    if (bursty) begin
      burst_left--;
      if (burst_left <= 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6) + (($urandom_range(0, 9) == 0) ? 20 : 0)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  task automatic hold_until_drained();
    if (s_tvalid) begin
      s_tvalid <= 1'b0;
    end
    @(posedge clk);
    while (pending_duties.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Half the voltages stay near the 0..12 V window so the duty is not always clamped.
  function automatic logic [15:0] random_voltage();
    if ($urandom_range(0, 1)) begin
      return 16'($urandom);
    end
    return 16'($urandom_range(0, 2 * VoltSmall) - VoltSmall);
  endfunction

  task automatic send_random_word();
    angle_src_e src;
    src = angle_src_e'($urandom_range(0, 1));
    send_word(src, random_voltage(), random_voltage(), 16'($urandom), $urandom,
              16'($urandom));
  endtask

  task automatic test_given_angle_corners();
    send_word(CmdGivenAngle, 16'd0, 16'd0, 16'd0, $urandom, 16'($urandom));
    send_word(CmdGivenAngle, 16'd0, 16'd1536, 16'd0, $urandom, 16'($urandom));
    send_word(CmdGivenAngle, 16'd0, 16'd3072, 16'd0, $urandom, 16'($urandom));
    send_word(CmdGivenAngle, 16'd0, 16'd3073, 16'd0, $urandom, 16'($urandom));
    send_word(CmdGivenAngle, 16'h8000, 16'd0, 16'd16384, $urandom, 16'($urandom));
    send_word(CmdGivenAngle, 16'h7FFF, 16'd0, 16'd16384, $urandom, 16'($urandom));
    send_word(CmdGivenAngle, 16'h7FFF, 16'h7FFF, 16'hFFFF, $urandom, 16'($urandom));
    send_word(CmdGivenAngle, 16'h8000, 16'h8000, 16'h8000, $urandom, 16'($urandom));
    send_word(CmdGivenAngle, 16'(-768), 16'd512, 16'd21845, $urandom, 16'($urandom));
    send_word(CmdGivenAngle, 16'd256, 16'(-1024), 16'd43690, $urandom, 16'($urandom));
    send_word(CmdGivenAngle, 16'(-1536), 16'd1536, 16'hC000, $urandom, 16'($urandom));
    send_word(CmdGivenAngle, 16'd0, 16'd3072, 16'd63, $urandom, 16'($urandom));
  endtask

  task automatic test_open_loop_angle();
    send_word(CmdOpenLoop, 16'(-1536), 16'h7FFF, 16'($urandom), 32'hFFFF_FFFF, 16'h8000);
    send_word(CmdOpenLoop, 16'(-3072), 16'h8000, 16'($urandom), 32'd0, 16'h7FFF);
    send_word(CmdOpenLoop, 16'h8000, 16'h1234, 16'($urandom), 32'd1000, 16'hFFFF);
    send_word(CmdOpenLoop, 16'd1536, 16'd0, 16'($urandom), 32'h0001_0000, 16'd1);
    send_word(CmdOpenLoop, 16'(-2000), 16'hFFFF, 16'($urandom), 32'hFFFF_FFFF, 16'h7FFF);
    send_word(CmdOpenLoop, 16'h7FFF, 16'd0, 16'($urandom), 32'h0001_2345, 16'd7);
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_random_word();
  endtask

  task automatic test_drain_pauses();
    repeat (4) begin
      repeat (50) send_random_word();
      hold_until_drained();
    end
  endtask

  task automatic test_full_rate();
    full_rate = 1'b1;
    bursty = 1'b0;
    repeat (150) send_random_word();
    full_rate = 1'b0;
    bursty = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_given_angle_corners();
    test_open_loop_angle();
    test_random_traffic(700);
    test_drain_pauses();
    test_full_rate();
    test_random_traffic(180);
    hold_until_drained();
    repeat (2 * PipeLatency) @(posedge clk);
    if (mismatch_count == 0 && pending_duties.size() == 0) begin
      $display("inverse_park_clarke_pwm_duty_top: match");
    end else begin
      $display("inverse_park_clarke_pwm_duty_top: mismatch");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/ipcpd_pkg.sv
rtl/core/ipcpd_ctrl.sv
rtl/core/ipcpd_sine.sv
rtl/core/ipcpd_phase.sv
rtl/core/inverse_park_clarke_pwm_duty_top.sv
sim/tb_top.sv
